// ===== rtl/sird_pkg.sv =====
// Shared types, constants and the reciprocal table for the radix digit converter.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package sird_pkg;

  // Fixed field widths
  localparam int IN_W       = 32;
  localparam int CHAR_W     = 8;
  localparam int RADIX_W    = 5;
  localparam int DIGIT_W    = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;
  localparam int ALPHA_W    = 128;

  // Register indexes on the configuration channel
  localparam logic [CFG_IDX_W-1:0] REG_DIGIT_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_LOW   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_HIGH  = 2'd2;

  // Register reset values ("01234567" and "89abcdef", byte 0 lowest)
  localparam logic [RADIX_W-1:0]    DIGIT_COUNT_RST = 5'd10;
  localparam logic [CFG_DATA_W-1:0] ALPHA_LOW_RST   = 64'h3736_3534_3332_3130;
  localparam logic [CFG_DATA_W-1:0] ALPHA_HIGH_RST  = 64'h6665_6463_6261_3938;

  localparam logic [CHAR_W-1:0] MINUS_CHAR = 8'h2D;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_FIX,
    ST_EMIT
  } sird_state_t;

  // Configuration as seen by the datapath
  typedef struct packed {
    logic [RADIX_W-1:0] radix;
    logic [ALPHA_W-1:0] alphabet;
  } sird_cfg_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic mul;
    logic fix;
    logic emit;
  } sird_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic q_zero;
    logic final_char;
    logic out_free;
  } sird_stat_t;

  // floor(2^32 / r) for r in 2..16
  function automatic logic [31:0] recip32(logic [RADIX_W-1:0] r);
    logic [31:0] v;
    case (r)
      5'd2:    v = 32'h8000_0000;
      5'd3:    v = 32'h5555_5555;
      5'd4:    v = 32'h4000_0000;
      5'd5:    v = 32'h3333_3333;
      5'd6:    v = 32'h2AAA_AAAA;
      5'd7:    v = 32'h2492_4924;
      5'd8:    v = 32'h2000_0000;
      5'd9:    v = 32'h1C71_C71C;
      5'd10:   v = 32'h1999_9999;
      5'd11:   v = 32'h1745_D174;
      5'd12:   v = 32'h1555_5555;
      5'd13:   v = 32'h13B1_3B13;
      5'd14:   v = 32'h1249_2492;
      5'd15:   v = 32'h1111_1111;
      5'd16:   v = 32'h1000_0000;
      default: v = 32'h8000_0000;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/sird_num_if.sv =====
// Input channel: one signed integer per transfer.
// Depends on sird_pkg.
`timescale 1ns / 1ps

interface sird_num_if;
  import sird_pkg::*;

  logic                   valid;
  logic                   ready;
  logic signed [IN_W-1:0] number_in;

  modport source (output valid, output number_in, input ready);
  modport sink   (input valid, input number_in, output ready);
endinterface

// ===== rtl/sird_char_if.sv =====
// Output channel: one character per transfer with an end-of-number flag.
// Depends on sird_pkg.
`timescale 1ns / 1ps

interface sird_char_if;
  import sird_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_out;
  logic              last_char;

  modport source (output valid, output char_out, output last_char, input ready);
  modport sink   (input valid, input char_out, input last_char, output ready);
endinterface

// ===== rtl/sird_cfg_if.sv =====
// Configuration write channel: register index and write data.
// Depends on sird_pkg.
`timescale 1ns / 1ps

interface sird_cfg_if;
  import sird_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/sird_regs.sv =====
// Configuration registers: digit count and the two alphabet words.
// Depends on sird_pkg and sird_cfg_if; produces the clamped radix.
`timescale 1ns / 1ps

module sird_regs #(
  parameter int MAX_RADIX = 16
) (
  input  logic               clk,
  input  logic               rst,
  sird_cfg_if.sink           cfg,
  output sird_pkg::sird_cfg_t cfg_out
);
  import sird_pkg::*;

  logic [RADIX_W-1:0]    digit_count;
  logic [CFG_DATA_W-1:0] alphabet_low;
  logic [CFG_DATA_W-1:0] alphabet_high;

  assign cfg.ready = 1'b1;

  // Register writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      digit_count   <= DIGIT_COUNT_RST;
      alphabet_low  <= ALPHA_LOW_RST;
      alphabet_high <= ALPHA_HIGH_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_DIGIT_COUNT: digit_count   <= cfg.data[RADIX_W-1:0];
        REG_ALPHA_LOW:   alphabet_low  <= cfg.data;
        REG_ALPHA_HIGH:  alphabet_high <= cfg.data;
        default: ;
      endcase
    end
  end

  // Clamp the radix to 2..MAX_RADIX
  always_comb begin
    if (digit_count < RADIX_W'(2)) begin
      cfg_out.radix = RADIX_W'(2);
    end else if (digit_count > RADIX_W'(MAX_RADIX)) begin
      cfg_out.radix = RADIX_W'(MAX_RADIX);
    end else begin
      cfg_out.radix = digit_count;
    end
    cfg_out.alphabet = {alphabet_high, alphabet_low};
  end

endmodule

// ===== rtl/sird_ctrl.sv =====
// Sequencer: accept, divide digit by digit, then emit characters.
// Depends on sird_pkg; drives the datapath through sird_cmd_t.
`timescale 1ns / 1ps

module sird_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  sird_pkg::sird_stat_t st,
  output sird_pkg::sird_cmd_t  cmd
);
  import sird_pkg::*;

  sird_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_FIX;
      end
      ST_FIX: begin
        cmd.fix    = 1'b1;
        state_next = st.q_zero ? ST_EMIT : ST_MUL;
      end
      ST_EMIT: begin
        if (st.out_free) begin
          cmd.emit = 1'b1;
          if (st.final_char) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// ===== rtl/sird_dp.sv =====
// Datapath: magnitude, reciprocal-multiply divider, digit store, output register.
// Depends on sird_pkg and sird_char_if.
`timescale 1ns / 1ps

module sird_dp #(
  parameter int VALUE_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [VALUE_BITS-1:0] raw,
  input  sird_pkg::sird_cfg_t   cfg,
  input  sird_pkg::sird_cmd_t   cmd,
  output sird_pkg::sird_stat_t  st,
  sird_char_if.source           text
);
  import sird_pkg::*;

  localparam int VB = VALUE_BITS;
  localparam int CW = $clog2(VB + 1);
  localparam int IW = $clog2(VB);

  logic [VB-1:0]      mag;
  logic [VB-1:0]      q_est;
  logic               neg;
  logic [CW-1:0]      count;
  logic [DIGIT_W-1:0] store [VB];
  logic               out_valid;
  logic [CHAR_W-1:0]  out_char;
  logic               out_last;

  logic [VB-1:0]      mag_in;
  logic [31:0]        recip_full;
  logic [VB-1:0]      recip;
  logic [2*VB-1:0]    prod;
  logic [9:0]         back_full;
  logic [RADIX_W-1:0] rem5;
  logic               over;
  logic [RADIX_W-1:0] digit_full;
  logic [DIGIT_W-1:0] digit;
  logic [VB-1:0]      q_fix;
  logic [CW-1:0]      rd_ptr;
  logic [CW-1:0]      rd_prev;
  logic [DIGIT_W-1:0] rd_digit;
  logic [CHAR_W-1:0]  glyph;

  // Two's complement magnitude; the most negative value maps to 2^(VB-1)
  assign mag_in = raw[VB-1] ? ((~raw) + VB'(1)) : raw;

  // Quotient estimate: floor(mag * floor(2^VB / r) / 2^VB), low by at most one
  assign recip_full = recip32(cfg.radix);
  assign recip      = recip_full[31 -: VB];
  assign prod       = (2*VB)'(mag) * (2*VB)'(recip);

  // Remainder is below 2r, so the low five bits of the difference are exact
  assign back_full  = 10'(q_est[RADIX_W-1:0]) * 10'(cfg.radix);
  assign rem5       = mag[RADIX_W-1:0] - back_full[RADIX_W-1:0];
  assign over       = (rem5 >= cfg.radix);
  assign digit_full = over ? (rem5 - cfg.radix) : rem5;
  assign digit      = digit_full[DIGIT_W-1:0];
  assign q_fix      = over ? (q_est + VB'(1)) : q_est;

  // Most significant stored digit first; rd_digit holds entry count-1
  assign rd_ptr  = count - CW'(1);
  assign rd_prev = count - CW'(2);
  assign glyph   = cfg.alphabet[{rd_digit, 3'b000} +: CHAR_W];

  assign st.q_zero     = (q_fix == '0);
  assign st.final_char = !neg && (count == CW'(1));
  assign st.out_free   = !out_valid || text.ready;

  // Divider and digit count
  always_ff @(posedge clk) begin
    if (rst) begin
      mag   <= '0;
      neg   <= 1'b0;
      count <= '0;
    end else if (cmd.load) begin
      mag   <= mag_in;
      neg   <= raw[VB-1];
      count <= '0;
    end else if (cmd.fix) begin
      mag   <= q_fix;
      count <= count + CW'(1);
    end else if (cmd.emit) begin
      if (neg) begin
        neg <= 1'b0;
      end else begin
        count <= rd_ptr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      q_est <= prod[2*VB-1:VB];
    end
  end

  // Digit store, least significant digit at entry 0; registered read
  // follows the top entry: the new digit on a store, the next one down on emit
  always_ff @(posedge clk) begin
    if (cmd.fix) begin
      store[count[IW-1:0]] <= digit;
      rd_digit             <= digit;
    end else if (cmd.emit && !neg) begin
      rd_digit <= store[rd_prev[IW-1:0]];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (text.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      if (neg) begin
        out_char <= MINUS_CHAR;
        out_last <= 1'b0;
      end else begin
        out_char <= glyph;
        out_last <= (count == CW'(1));
      end
    end
  end

  assign text.valid     = out_valid;
  assign text.char_out  = out_char;
  assign text.last_char = out_last;

  // Digit count never runs past the store
  a_store_room: assert property (@(posedge clk) disable iff (rst)
    cmd.fix |-> (count < CW'(VB)))
    else $error("digit store overflow");

  // Corrected remainder is a valid digit
  a_digit_range: assert property (@(posedge clk) disable iff (rst)
    cmd.fix |-> (RADIX_W'(digit) < cfg.radix))
    else $error("remainder not below radix");

  // Estimated quotient never exceeds the dividend
  a_q_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.fix |-> (q_est <= mag))
    else $error("quotient estimate too large");

  // The final character is presented with its flag set
  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && st.final_char) |=> (text.valid && text.last_char))
    else $error("final character lost its flag");

endmodule

// ===== rtl/signed_integer_to_radix_digits_core.sv =====
// Top level of the signed integer to radix digit text converter.
// Depends on sird_pkg, the three channel interfaces, sird_regs, sird_ctrl and sird_dp.
`timescale 1ns / 1ps

// Each accepted integer is written out in the configured radix (2..MAX_RADIX),
// most significant character first, with a leading '-' for negative values and
// last_char set on the final character. Each item is accepted, divided digit by
// digit in the shared reciprocal-multiply divider (multiply, then correct and
// store), and then written out character by character, stalling while the
// output is not ready. A new item is taken once the previous one's last
// character sits in the output register.
// Configuration writes are always taken; make them while no number is in flight.
module signed_integer_to_radix_digits_core #(
  parameter int MAX_RADIX  = 16,
  parameter int VALUE_BITS = 32
) (
  input  logic       clk,
  input  logic       rst,
  sird_cfg_if.sink   cfg,
  sird_num_if.sink   number,
  sird_char_if.source text
);
  import sird_pkg::*;

  sird_cfg_t  cfg_val;
  sird_cmd_t  cmd;
  sird_stat_t st;

  sird_regs #(
    .MAX_RADIX (MAX_RADIX)
  ) u_regs (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .cfg_out (cfg_val)
  );

  sird_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (number.valid),
    .in_ready (number.ready),
    .st       (st),
    .cmd      (cmd)
  );

  sird_dp #(
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk  (clk),
    .rst  (rst),
    .raw  (number.number_in[VALUE_BITS-1:0]),
    .cfg  (cfg_val),
    .cmd  (cmd),
    .st   (st),
    .text (text)
  );

endmodule

// ===== tb/sv/signed_integer_to_radix_digits_core_test.sv =====
// Self-checking testbench for signed_integer_to_radix_digits_core: drives numbers and
// register writes, predicts the emitted text and checks every character transfer.
// Depends on sird_pkg, the three channel interfaces and the core RTL.
`timescale 1ns / 1ps

module signed_integer_to_radix_digits_core_test;
  import sird_pkg::*;

  localparam int          RADIX_MAX = 16;
  localparam int unsigned RUN_LIMIT = 600000;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam logic [CHAR_W-1:0]    SIGN_CHAR = 8'h2D;

  typedef struct {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } text_char_t;

  logic clk;
  logic rst;

  sird_cfg_if  cfg_ch ();
  sird_num_if  num_ch ();
  sird_char_if text_ch ();

  signed_integer_to_radix_digits_core dut (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_ch),
    .number (num_ch),
    .text   (text_ch)
  );

  // Shadow copy of the format registers
  logic [RADIX_W-1:0] shadow_count = 5'd10;
  logic [ALPHA_W-1:0] shadow_alpha = {64'h6665_6463_6261_3938, 64'h3736_3534_3332_3130};

  text_char_t  expected_text[$];
  int          mismatches  = 0;
  bit          steady_flow = 1'b0;
  int unsigned cycle_count = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Known values on every input from time zero
  initial begin
    rst              <= 1'b1;
    cfg_ch.valid     <= 1'b0;
    cfg_ch.index     <= REG_DIGIT_COUNT;
    cfg_ch.data      <= '0;
    num_ch.valid     <= 1'b0;
    num_ch.number_in <= '0;
  end

  function automatic void note_mismatch(input string detail);
    mismatches++;
    if (mismatches <= 10) $display("mismatch %0d at %0t: %s", mismatches, $realtime, detail);
  endfunction

  // Radix below 2 acts as 2, above the maximum as the maximum
  function automatic int unsigned effective_radix();
    if (shadow_count < 2) return 2;
    if (shadow_count > RADIX_MAX) return RADIX_MAX;
    return 32'(shadow_count);
  endfunction

  // Expected characters for one number under the current format
  function automatic void predict_text(input logic [IN_W-1:0] value);
    int unsigned       radix;
    logic [IN_W-1:0]   mag;
    logic [DIGIT_W-1:0] digits[$];
    text_char_t        c;
    radix = effective_radix();
    // two's complement negate; the most negative value maps onto 2^31
    mag = value[IN_W-1] ? (~value + IN_W'(1)) : value;
    do begin
      digits.push_back(DIGIT_W'(mag % radix));
      mag = mag / radix;
    end while (mag != 0);
    if (value[IN_W-1]) begin
      c.ch   = SIGN_CHAR;
      c.last = 1'b0;
      expected_text.push_back(c);
    end
    for (int i = digits.size() - 1; i >= 0; i--) begin
      c.ch   = shadow_alpha[digits[i] * 8 +: 8];
      c.last = (i == 0);
      expected_text.push_back(c);
    end
  endfunction

  function automatic logic [IN_W-1:0] random_number();
    logic [63:0]     power;
    logic [IN_W-1:0] value;
    int unsigned     r;
    r     = effective_radix();
    power = 64'd1;
    case ($urandom_range(0, 7))
      0, 1: value = $urandom;
      2, 3: begin
        value = $urandom >> $urandom_range(0, 31);
        if ($urandom_range(0, 1)) value = ~value + IN_W'(1);
      end
      4: value = 32'h8000_0000 + $urandom_range(0, 2);
      5: value = 32'h7FFF_FFFF - $urandom_range(0, 2);
      default: begin
        // near a power of the radix, where the digit count steps
        repeat ($urandom_range(1, 31)) begin
          if (power * 64'(r) <= 64'h8000_0000) power = power * 64'(r);
        end
        value = power[IN_W-1:0] - $urandom_range(0, 1);
        if ($urandom_range(0, 1)) value = ~value + IN_W'(1);
      end
    endcase
    return value;
  endfunction

  // One number transfer; valid stays high until the next idle or drain
  task automatic send_number(input logic [IN_W-1:0] value);
    if (!steady_flow) begin
      while ($urandom_range(0, 99) < 33) begin
        num_ch.valid <= 1'b0;
        @(posedge clk);
      end
    end
    num_ch.valid     <= 1'b1;
    num_ch.number_in <= value;
    do @(posedge clk); while (!num_ch.ready);
    predict_text(value);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      REG_DIGIT_COUNT: shadow_count = value[RADIX_W-1:0];
      REG_ALPHA_LOW:   shadow_alpha[63:0] = value;
      REG_ALPHA_HIGH:  shadow_alpha[127:64] = value;
      default: ;
    endcase
  endtask

  task automatic set_format(input logic [RADIX_W-1:0] count,
                            input logic [CFG_DATA_W-1:0] low,
                            input logic [CFG_DATA_W-1:0] high);
    write_register(REG_DIGIT_COUNT, CFG_DATA_W'(count));
    write_register(REG_ALPHA_LOW, low);
    write_register(REG_ALPHA_HIGH, high);
    cfg_ch.valid <= 1'b0;
  endtask

  // Stop sending and wait until every expected character has come out
  task automatic wait_drained();
    num_ch.valid <= 1'b0;
    do @(posedge clk); while (expected_text.size() != 0);
  endtask

  // Output side: random backpressure and in-order character check
  always @(posedge clk) begin
    text_char_t want;
    if (rst) text_ch.ready <= 1'b0;
    else text_ch.ready <= steady_flow || ($urandom_range(0, 99) >= 33);
    if (!rst && text_ch.valid && text_ch.ready) begin
      if (expected_text.size() == 0) begin
        note_mismatch($sformatf("char %02h last %0b with nothing expected",
                                text_ch.char_out, text_ch.last_char));
      end else begin
        want = expected_text.pop_front();
        if (text_ch.char_out !== want.ch)
          note_mismatch($sformatf("char_out expected %02h got %02h",
                                  want.ch, text_ch.char_out));
        if (text_ch.last_char !== want.last)
          note_mismatch($sformatf("last_char expected %0b got %0b",
                                  want.last, text_ch.last_char));
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Reset format: zero, unit values and both ends of the range
  task automatic test_reset_format();
    send_number(32'd0);
    send_number(32'd1);
    send_number(32'hFFFF_FFFF);
    send_number(32'h7FFF_FFFF);
    send_number(32'h8000_0000);
    send_number(-32'sd10);
  endtask

  // Smallest and largest radix, and counts outside the legal range
  task automatic test_radix_limits();
    wait_drained();
    set_format(5'd2, {$urandom, $urandom}, {$urandom, $urandom});
    send_number(32'h8000_0000);
    send_number(32'h7FFF_FFFF);
    send_number(32'd0);
    wait_drained();
    set_format(5'd16, {$urandom, $urandom}, {$urandom, $urandom});
    send_number(32'h8000_0000);
    send_number(32'hFFFF_FFFF);
    send_number(32'h7FFF_FFFF);
    wait_drained();
    set_format(5'd0, {$urandom, $urandom}, {$urandom, $urandom});
    send_number(32'd5);
    wait_drained();
    set_format(5'd1, {$urandom, $urandom}, {$urandom, $urandom});
    send_number(-32'sd6);
    wait_drained();
    set_format(5'd17, {$urandom, $urandom}, {$urandom, $urandom});
    send_number(32'h8000_0000);
    wait_drained();
    set_format(5'd31, {$urandom, $urandom}, {$urandom, $urandom});
    send_number(32'h7FFF_FFFF);
  endtask

  // Alphabet bytes are used raw: zero bytes, sign bytes, all ones
  task automatic test_alphabet_bytes();
    wait_drained();
    set_format(5'd3, 64'h2D00_2D00_2D00_2D00, 64'h0);
    send_number(-32'sd7);
    wait_drained();
    set_format(5'd10, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF);
    send_number(32'd98);
  endtask

  // A write to the spare index must leave the format alone
  task automatic test_spare_register();
    wait_drained();
    write_register(REG_SPARE, 64'hFFFF_FFFF_FFFF_FFFF);
    cfg_ch.valid <= 1'b0;
    send_number(32'd12345);
  endtask

  task automatic test_random_formats();
    logic [RADIX_W-1:0] count;
    repeat (6) begin
      wait_drained();
      count = ($urandom_range(0, 9) == 0) ? RADIX_W'($urandom_range(0, 31))
                                          : RADIX_W'($urandom_range(2, 16));
      set_format(count, {$urandom, $urandom}, {$urandom, $urandom});
      repeat (15) send_number(random_number());
    end
  endtask

  // Long stretch with no gaps on either side
  task automatic test_steady_flow();
    wait_drained();
    steady_flow = 1'b1;
    set_format(RADIX_W'($urandom_range(2, 16)), {$urandom, $urandom}, {$urandom, $urandom});
    repeat (22) send_number(random_number());
    wait_drained();
    steady_flow = 1'b0;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_reset_format();
    test_radix_limits();
    test_alphabet_bytes();
    test_spare_register();
    test_random_formats();
    test_steady_flow();
    wait_drained();
    repeat (120) @(posedge clk);
    if (mismatches == 0 && expected_text.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
